FILE: rtl/srsf_pkg.sv
// Shared types and constants of the socket ring SPI framer.
`timescale 1ns / 1ps
package srsf_pkg;

  localparam int unsigned SOCKET_BUF_SIZE = 2048;
  localparam int unsigned SOCKET_COUNT    = 4;
  localparam int unsigned BUF_BITS        = $clog2(SOCKET_BUF_SIZE);

  localparam logic [15:0] OFFSET_MASK = 16'((1 << BUF_BITS) - 1);

  localparam logic [7:0] CMD_WRITE = 8'hF0;
  localparam logic [7:0] CMD_READ  = 8'h0F;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic REG_TX_BASE = 1'b0;
  localparam logic REG_RX_BASE = 1'b1;

  localparam logic [15:0] TX_BASE_RESET = 16'h4000;
  localparam logic [15:0] RX_BASE_RESET = 16'h6000;

  localparam logic [1:0] BYTE_CMD     = 2'd0;
  localparam logic [1:0] BYTE_ADDR_HI = 2'd1;
  localparam logic [1:0] BYTE_ADDR_LO = 2'd2;
  localparam logic [1:0] BYTE_DATA    = 2'd3;

  typedef struct packed {
    logic [7:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [15:0] new_ptr;
    logic        ptr_valid;
  } frame_t;

  typedef struct packed {
    logic        op;
    logic [1:0]  socket;
    logic [15:0] ring_pointer;
    logic [15:0] displacement;
    logic [15:0] byte_index;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        peek;
  } item_t;

  function automatic logic [1:0] socket_wrap(input logic [1:0] sock);
    logic [2:0] s;
    s = {1'b0, sock};
    for (int i = 0; i < 3; i++) begin
      if (s >= 3'(SOCKET_COUNT)) begin
        s = s - 3'(SOCKET_COUNT);
      end
    end
    return s[1:0];
  endfunction

endpackage

FILE: rtl/socket_ring_spi_framer_top.sv
// Top level of the socket ring SPI framer.
// An accepted item goes through the input register and then the frame register
// before its first SPI byte shows. Each input item yields four output items, and
// the single output port sends one frame byte per cycle while out_stall_i is low.
// The input register takes the next item while the frame register drains.
// Reset is asynchronous, active low: both stages empty, base registers at defaults.
`timescale 1ns / 1ps
module socket_ring_spi_framer_top import srsf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [1:0]  socket_i,
  input  logic [15:0] ring_pointer_i,
  input  logic [15:0] displacement_i,
  input  logic [15:0] byte_index_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        peek_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  spi_byte_o,
  output logic        frame_end_o,
  output logic [15:0] new_pointer_o,
  output logic        pointer_valid_o
);

  logic [15:0] tx_base;
  logic [15:0] rx_base;
  item_t       item_q;
  logic        item_valid_q, item_valid_d;
  frame_t      frame;
  logic        frame_free;
  logic        load;
  logic        in_take;

  srsf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .tx_base_o   (tx_base),
    .rx_base_o   (rx_base)
  );

  assign load       = item_valid_q && frame_free;
  assign in_stall_o = item_valid_q && !load;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    item_valid_d = item_valid_q;
    if (in_take) begin
      item_valid_d = 1'b1;
    end else if (load) begin
      item_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.op           <= operation_i;
      item_q.socket       <= socket_i;
      item_q.ring_pointer <= ring_pointer_i;
      item_q.displacement <= displacement_i;
      item_q.byte_index   <= byte_index_i;
      item_q.data_byte    <= data_byte_i;
      item_q.last_byte    <= last_byte_i;
      item_q.peek         <= peek_i;
    end
  end

  srsf_addr_gen u_addr (
    .item_i    (item_q),
    .tx_base_i (tx_base),
    .rx_base_i (rx_base),
    .frame_o   (frame)
  );

  srsf_frame_ser u_ser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .load_i          (load),
    .frame_i         (frame),
    .free_o          (frame_free),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .spi_byte_o      (spi_byte_o),
    .frame_end_o     (frame_end_o),
    .new_pointer_o   (new_pointer_o),
    .pointer_valid_o (pointer_valid_o)
  );

endmodule

FILE: rtl/srsf_cfg_regs.sv
// Base address registers of the transmit and receive buffers.
`timescale 1ns / 1ps
module srsf_cfg_regs import srsf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic [15:0] tx_base_o,
  output logic [15:0] rx_base_o
);

  logic [15:0] tx_base_q;
  logic [15:0] rx_base_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_base_q <= TX_BASE_RESET;
      rx_base_q <= RX_BASE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TX_BASE: tx_base_q <= cfg_data_i;
        REG_RX_BASE: rx_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign tx_base_o = tx_base_q;
  assign rx_base_o = rx_base_q;

endmodule

FILE: rtl/srsf_addr_gen.sv
// Chip address, frame bytes and advanced ring pointer for one item.
`timescale 1ns / 1ps
module srsf_addr_gen import srsf_pkg::*; (
  input  item_t       item_i,
  input  logic [15:0] tx_base_i,
  input  logic [15:0] rx_base_i,
  output frame_t      frame_o
);

  logic        is_read;
  logic [15:0] disp;
  logic [15:0] ring_sum;
  logic [15:0] sock_off;
  logic [15:0] base;

  always_comb begin
    is_read  = (item_i.op == OP_READ);
    disp     = is_read ? 16'd0 : item_i.displacement;
    ring_sum = item_i.ring_pointer + disp + item_i.byte_index;
    sock_off = 16'({14'd0, socket_wrap(item_i.socket)} << BUF_BITS);
    base     = is_read ? rx_base_i : tx_base_i;

    frame_o.cmd       = is_read ? CMD_READ : CMD_WRITE;
    frame_o.addr      = base + sock_off + (ring_sum & OFFSET_MASK);
    frame_o.data      = is_read ? 8'd0 : item_i.data_byte;
    frame_o.ptr_valid = item_i.last_byte && !(is_read && item_i.peek);
    frame_o.new_ptr   = frame_o.ptr_valid ? (ring_sum + 16'd1) : 16'd0;
  end

endmodule

FILE: rtl/srsf_frame_ser.sv
// Frame register and byte sequencer that sends one frame as four items.
`timescale 1ns / 1ps
module srsf_frame_ser import srsf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  frame_t      frame_i,
  output logic        free_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  spi_byte_o,
  output logic        frame_end_o,
  output logic [15:0] new_pointer_o,
  output logic        pointer_valid_o
);

  frame_t     frame_q;
  logic       busy_q, busy_d;
  logic [1:0] cnt_q, cnt_d;
  logic       out_take;
  logic       done;

  assign out_take = busy_q && !out_stall_i;
  assign done     = out_take && (cnt_q == BYTE_DATA);
  assign free_o   = !busy_q || done;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (load_i) begin
      busy_d = 1'b1;
      cnt_d  = BYTE_CMD;
    end else if (done) begin
      busy_d = 1'b0;
      cnt_d  = BYTE_CMD;
    end else if (out_take) begin
      cnt_d  = cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= BYTE_CMD;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      frame_q <= frame_i;
    end
  end

  always_comb begin
    frame_end_o     = 1'b0;
    new_pointer_o   = 16'd0;
    pointer_valid_o = 1'b0;
    unique case (cnt_q)
      BYTE_CMD:     spi_byte_o = frame_q.cmd;
      BYTE_ADDR_HI: spi_byte_o = frame_q.addr[15:8];
      BYTE_ADDR_LO: spi_byte_o = frame_q.addr[7:0];
      BYTE_DATA: begin
        spi_byte_o      = frame_q.data;
        frame_end_o     = 1'b1;
        new_pointer_o   = frame_q.new_ptr;
        pointer_valid_o = frame_q.ptr_valid;
      end
      default: spi_byte_o = frame_q.cmd;
    endcase
  end

  assign out_valid_o = busy_q;

endmodule

FILE: test/srsf_checker.sv
// Scoreboard for the socket ring SPI framer: predicts each frame and compares the bytes.
`timescale 1ns / 1ps
module srsf_checker import srsf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  item_t       item_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  spi_byte_i,
  input  logic        frame_end_i,
  input  logic [15:0] new_pointer_i,
  input  logic        pointer_valid_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [7:0]  spi;
    logic        fend;
    logic [15:0] ptr;
    logic        pvalid;
  } spi_beat_t;

  spi_beat_t   spi_beat_q[$];
  logic [15:0] tx_base;
  logic [15:0] rx_base;
  int unsigned mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic queue_frame(input item_t it);
    logic        is_rd;
    int unsigned sock;
    logic [15:0] span;
    logic [15:0] addr;
    logic        pvalid;
    logic [15:0] newp;
    spi_beat_t   beat;
    is_rd  = (it.op == OP_READ);
    sock   = it.socket % SOCKET_COUNT;
    span   = it.ring_pointer + (is_rd ? 16'd0 : it.displacement) + it.byte_index;
    addr   = (is_rd ? rx_base : tx_base) + 16'(sock * SOCKET_BUF_SIZE)
             + (span & 16'(SOCKET_BUF_SIZE - 1));
    pvalid = it.last_byte && !(is_rd && it.peek);
    newp   = pvalid ? span + 16'd1 : 16'd0;
    beat   = '{spi: (is_rd ? CMD_READ : CMD_WRITE), fend: 1'b0, ptr: 16'd0, pvalid: 1'b0};
    spi_beat_q.push_back(beat);
    beat.spi = addr[15:8];
    spi_beat_q.push_back(beat);
    beat.spi = addr[7:0];
    spi_beat_q.push_back(beat);
    beat = '{spi: (is_rd ? 8'h00 : it.data_byte), fend: 1'b1, ptr: newp, pvalid: pvalid};
    spi_beat_q.push_back(beat);
  endtask

  task automatic check_beat();
    spi_beat_t want;
    if (spi_beat_q.size() == 0) begin
      report_mismatch("unexpected spi byte", spi_byte_i, 0);
    end else begin
      want = spi_beat_q.pop_front();
      if (spi_byte_i !== want.spi) report_mismatch("spi_byte", spi_byte_i, want.spi);
      if (frame_end_i !== want.fend) report_mismatch("frame_end", frame_end_i, want.fend);
      if (new_pointer_i !== want.ptr) report_mismatch("new_pointer", new_pointer_i, want.ptr);
      if (pointer_valid_i !== want.pvalid) begin
        report_mismatch("pointer_valid", pointer_valid_i, want.pvalid);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_base = TX_BASE_RESET;
      rx_base = RX_BASE_RESET;
      spi_beat_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_TX_BASE) tx_base = cfg_data_i;
        else rx_base = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) queue_frame(item_i);
      if (out_valid_i && !out_stall_i) check_beat();
    end
    pending_o <= spi_beat_q.size();
  end

endmodule

FILE: test/testbench.sv
// Top of the socket ring SPI framer test: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench import srsf_pkg::*;;

  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned PHASE_ITEMS = 31;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_index = REG_TX_BASE;
  logic [15:0] cfg_data = 16'd0;
  logic        cfg_ready_o;
  logic        in_valid = 1'b0;
  item_t       in_item = '0;
  logic        in_stall_o;
  logic        out_stall = 1'b0;
  logic        out_valid_o;
  logic [7:0]  spi_byte_o;
  logic        frame_end_o;
  logic [15:0] new_pointer_o;
  logic        pointer_valid_o;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles = 0;
  bit          no_idle = 1'b0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;

  socket_ring_spi_framer_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .operation_i    (in_item.op),
    .socket_i       (in_item.socket),
    .ring_pointer_i (in_item.ring_pointer),
    .displacement_i (in_item.displacement),
    .byte_index_i   (in_item.byte_index),
    .data_byte_i    (in_item.data_byte),
    .last_byte_i    (in_item.last_byte),
    .peek_i         (in_item.peek),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .spi_byte_o     (spi_byte_o),
    .frame_end_o    (frame_end_o),
    .new_pointer_o  (new_pointer_o),
    .pointer_valid_o(pointer_valid_o)
  );

  srsf_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall_o),
    .item_i         (in_item),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall),
    .spi_byte_i     (spi_byte_o),
    .frame_end_i    (frame_end_o),
    .new_pointer_i  (new_pointer_o),
    .pointer_valid_i(pointer_valid_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // hold off once for a long stretch so the block backs up into its input
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (80) @(posedge clk_i);
      end else begin
        out_stall <= !no_idle && ($urandom_range(99) < 24);
      end
    end
  end

  function automatic item_t make_item(input logic op, input logic [1:0] sock,
                                      input logic [15:0] ptr, input logic [15:0] disp,
                                      input logic [15:0] idx, input logic [7:0] data,
                                      input logic last, input logic peek);
    item_t it;
    it.op           = op;
    it.socket       = sock;
    it.ring_pointer = ptr;
    it.displacement = disp;
    it.byte_index   = idx;
    it.data_byte    = data;
    it.last_byte    = last;
    it.peek         = peek;
    return it;
  endfunction

  task automatic offer_item(input item_t it);
    while (!no_idle && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_bases(input logic [15:0] tx, input logic [15:0] rx);
    cfg_valid <= 1'b1;
    cfg_index <= REG_TX_BASE;
    cfg_data  <= tx;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index <= REG_RX_BASE;
    cfg_data  <= rx;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_transfers(input int unsigned quota);
    item_t       it;
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(99) < 20) begin
        it = make_item(1'($urandom_range(1)), 2'($urandom_range(3)), 16'($urandom),
                       16'($urandom), 16'($urandom), 8'($urandom),
                       1'($urandom_range(1)), 1'($urandom_range(1)));
        offer_item(it);
        sent++;
      end else begin
        len = $urandom_range(6, 1);
        it.op           = 1'($urandom_range(1));
        it.socket       = 2'($urandom_range(3));
        it.ring_pointer = 16'($urandom);
        it.peek         = 1'($urandom_range(1));
        if (it.op == OP_READ) begin
          it.displacement = ($urandom_range(3) == 0) ? 16'($urandom) : 16'd0;
        end else begin
          it.displacement = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(15));
        end
        for (int k = 0; k < len; k++) begin
          it.byte_index = 16'(k);
          it.data_byte  = 8'($urandom);
          it.last_byte  = (k == len - 1);
          offer_item(it);
          sent++;
        end
      end
    end
  endtask

  initial begin
    logic [15:0] tx_set[5];
    logic [15:0] rx_set[5];
    tx_set = '{TX_BASE_RESET, 16'h0000, 16'hFFFF, 16'hF9AB, 16'($urandom)};
    rx_set = '{RX_BASE_RESET, 16'hFFFF, 16'h0000, 16'hFC01, 16'($urandom)};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    offer_item(make_item(OP_WRITE, 2'd0, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0));
    offer_item(make_item(OP_WRITE, 2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1));
    offer_item(make_item(OP_READ,  2'd0, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b0));
    offer_item(make_item(OP_READ,  2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1));
    offer_item(make_item(OP_READ,  2'd1, 16'h07FF, 16'h1234, 16'h0001, 8'hA5, 1'b1, 1'b0));
    offer_item(make_item(OP_WRITE, 2'd2, 16'h07FE, 16'h0001, 16'h0001, 8'h5A, 1'b1, 1'b0));
    offer_item(make_item(OP_WRITE, 2'd1, 16'h1000, 16'h0000, 16'h0000, 8'h55, 1'b0, 1'b1));
    offer_item(make_item(OP_READ,  2'd2, 16'h0800, 16'h0000, 16'h0003, 8'h00, 1'b0, 1'b1));
    offer_item(make_item(OP_WRITE, 2'd0, 16'h8000, 16'h8000, 16'h0000, 8'hF0, 1'b1, 1'b0));
    offer_item(make_item(OP_READ,  2'd3, 16'h7FFF, 16'h0000, 16'h0001, 8'hC3, 1'b1, 1'b1));
    run_transfers(PHASE_ITEMS);

    for (int p = 1; p < 5; p++) begin
      drain();
      write_bases(tx_set[p], rx_set[p]);
      no_idle = (p == 2);
      if (p == 3) hold_req = 1'b1;
      run_transfers(PHASE_ITEMS);
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/srsf_pkg.sv
rtl/srsf_cfg_regs.sv
rtl/srsf_addr_gen.sv
rtl/srsf_frame_ser.sv
rtl/socket_ring_spi_framer_top.sv
test/srsf_checker.sv
test/testbench.sv
